[hw/rtl/cprd_pkg.sv]
`default_nettype none
package cprd_pkg;

   localparam int unsigned PAL_DEPTH = 256;
   localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);
   localparam int unsigned OVL_DEPTH = 4;
   localparam int unsigned OVL_AW    = $clog2(OVL_DEPTH);

   localparam logic [15:0] READ_PREFIX  = 16'hFF00;
   localparam logic [15:0] REV_VALUE    = 16'hFF01;
   localparam logic [15:0] UNMAPPED_VAL = 16'hFFFF;
   localparam int unsigned OVL_SEL_EN_BIT = 3;

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      SEL_BUSY       = 4'd0,
      SEL_RED        = 4'd1,
      SEL_GREEN      = 4'd2,
      SEL_BLUE       = 4'd3,
      SEL_INDEX_INV  = 4'd4,
      SEL_INDEX      = 4'd5,
      SEL_OVL_CTL    = 4'd6,
      SEL_WR_STROBE  = 4'd7,
      SEL_RD_STROBE  = 4'd8,
      SEL_PLANE_MASK = 4'd9,
      SEL_SPARE      = 4'd10,
      SEL_OVL_INDEX  = 4'd11,
      SEL_REV        = 4'd12
   } sel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef struct packed {
      logic       en;
      logic [3:0] sel;
      logic [7:0] data;
   } reg_write_type;

   typedef struct packed {
      logic      en;
      color_type color;
   } held_load_type;

   typedef struct packed {
      color_type  held;
      logic [7:0] color_index;
      logic [7:0] plane_mask;
      logic [7:0] overlay_control;
      logic [7:0] overlay_select;
      logic [7:0] spare_byte;
   } reg_state_type;

endpackage
`default_nettype wire

[hw/rtl/cprd_if.sv]
`default_nettype none
interface cprd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] reg_select;
   logic [7:0] write_data;
   logic [7:0] pixel;
   logic [7:0] overlay_bits;

   modport source (output valid, mode, reg_select, write_data, pixel, overlay_bits,
                   input ready);
   modport sink (input valid, mode, reg_select, write_data, pixel, overlay_bits,
                 output ready);
endinterface

interface cprd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;

   modport source (output valid, read_data, red_out, green_out, blue_out,
                   input ready);
   modport sink (input valid, read_data, red_out, green_out, blue_out,
                 output ready);
endinterface
`default_nettype wire

[hw/rtl/cprd_ram.sv]
`default_nettype none
module cprd_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/cprd_regs.sv]
`default_nettype none
module cprd_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cprd_pkg::reg_write_type         wr,
   input  wire cprd_pkg::held_load_type         load,
   input  wire logic [cprd_pkg::PAL_AW-1:0]     lookup_addr,
   input  wire logic [cprd_pkg::OVL_AW-1:0]     ovl_addr,
   output      cprd_pkg::reg_state_type         state,
   output      logic                            entry_valid,
   output      cprd_pkg::color_type             ovl_color
);
   import cprd_pkg::*;

   reg_state_type state_ff, state_in;
   color_type     ovl_pal_ff [OVL_DEPTH];
   logic [PAL_DEPTH-1:0] pal_valid_ff;
   logic          wr_strobe;
   logic          ovl_target;

   assign wr_strobe  = wr.en && (wr.sel == SEL_WR_STROBE);
   assign ovl_target = state_ff.overlay_select[OVL_SEL_EN_BIT];

   always_comb begin
      state_in = state_ff;
      if (load.en) begin
         state_in.held = load.color;
      end else if (wr.en) begin
         unique case (sel_type'(wr.sel))
            SEL_RED:        state_in.held.red       = wr.data;
            SEL_GREEN:      state_in.held.green     = wr.data;
            SEL_BLUE:       state_in.held.blue      = wr.data;
            SEL_INDEX_INV:  state_in.color_index    = ~wr.data;
            SEL_INDEX:      state_in.color_index    = wr.data;
            SEL_OVL_CTL:    state_in.overlay_control = wr.data;
            SEL_PLANE_MASK: state_in.plane_mask     = wr.data;
            SEL_SPARE:      state_in.spare_byte     = wr.data;
            SEL_OVL_INDEX:  state_in.overlay_select = wr.data;
            default:        state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         pal_valid_ff <= '0;
         for (int i = 0; i < OVL_DEPTH; i++) begin
            ovl_pal_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (wr_strobe && ovl_target) begin
            ovl_pal_ff[state_ff.overlay_select[OVL_AW:1]] <= state_ff.held;
         end
         if (wr_strobe && !ovl_target) begin
            pal_valid_ff[state_ff.color_index] <= 1'b1;
         end
      end
   end

   assign state       = state_ff;
   assign entry_valid = pal_valid_ff[lookup_addr];
   assign ovl_color   = ovl_pal_ff[ovl_addr];

endmodule
`default_nettype wire

[hw/rtl/color_palette_ramdac.sv]
`default_nettype none
// Channel  Dir  Payload                                          Handshake
// req      in   mode, reg_select, write_data, pixel, overlay_bits valid/ready
// rsp      out  read_data, red_out, green_out, blue_out           valid/ready
//
// One request per cycle when req.ready is high; a result follows next cycle.
// A read strobe adds a bubble: the palette data loads the held color the
// cycle after it is accepted, and req.ready is low for that cycle.
// Synchronous reset clears the control, overlay and handshake registers and
// marks every palette entry black; req.ready is low while reset is high.
// A stalled rsp holds its result and blocks new requests until taken.
module color_palette_ramdac (
   input wire logic  clock,
   input wire logic  reset,
   cprd_req_if.sink  req,
   cprd_rsp_if.source rsp
);
   import cprd_pkg::*;

   reg_write_type       wr;
   held_load_type       load;
   reg_state_type       state;
   logic                entry_valid;
   color_type           ovl_color;
   color_type           ram_rd_data;
   logic [PAL_AW-1:0]   rd_addr;
   logic [PAL_AW-1:0]   pix_addr;
   logic [7:0]          ovl_hit;
   logic [7:0]          ovl_idx;
   logic                accept;
   logic                is_lookup;
   logic                is_rd_strobe;
   logic [15:0]         bus_value;

   logic        rsp_valid_ff;
   logic [15:0] read_data_ff, read_data_in;
   color_type   color_ff, color_in;
   logic        use_ram_ff, use_ram_in;
   logic        ent_valid_ff;
   logic        load_pend_ff;

   assign accept       = req.valid && req.ready;
   assign req.ready    = !reset && !load_pend_ff && (!rsp_valid_ff || rsp.ready);
   assign is_lookup    = (mode_type'(req.mode) == MODE_LOOKUP);
   assign is_rd_strobe = (mode_type'(req.mode) == MODE_WRITE)
                         && (sel_type'(req.reg_select) == SEL_RD_STROBE);

   assign wr.en   = accept && (mode_type'(req.mode) == MODE_WRITE);
   assign wr.sel  = req.reg_select;
   assign wr.data = req.write_data;

   assign load.en    = load_pend_ff;
   assign load.color = ent_valid_ff ? ram_rd_data : '0;

   assign ovl_hit  = req.overlay_bits & state.overlay_control;
   assign ovl_idx  = ovl_hit & state.plane_mask;
   assign pix_addr = req.pixel & state.plane_mask;
   assign rd_addr  = is_rd_strobe ? state.color_index : pix_addr;

   cprd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .load        (load),
      .lookup_addr (rd_addr),
      .ovl_addr    (ovl_idx[OVL_AW-1:0]),
      .state       (state),
      .entry_valid (entry_valid),
      .ovl_color   (ovl_color)
   );

   cprd_ram #(
      .WIDTH ($bits(color_type)),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr.en && (sel_type'(wr.sel) == SEL_WR_STROBE)
                && !state.overlay_select[OVL_SEL_EN_BIT]),
      .wr_addr (state.color_index),
      .wr_data (state.held),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      unique case (sel_type'(req.reg_select))
         SEL_BUSY:       bus_value = '0;
         SEL_RED:        bus_value = READ_PREFIX | {8'd0, state.held.red};
         SEL_GREEN:      bus_value = READ_PREFIX | {8'd0, state.held.green};
         SEL_BLUE:       bus_value = READ_PREFIX | {8'd0, state.held.blue};
         SEL_INDEX_INV:  bus_value = READ_PREFIX | {8'd0, ~state.color_index};
         SEL_INDEX:      bus_value = READ_PREFIX | {8'd0, state.color_index};
         SEL_OVL_CTL:    bus_value = READ_PREFIX | {8'd0, state.overlay_control};
         SEL_WR_STROBE:  bus_value = READ_PREFIX;
         SEL_PLANE_MASK: bus_value = READ_PREFIX | {8'd0, state.plane_mask};
         SEL_SPARE:      bus_value = READ_PREFIX | {8'd0, state.spare_byte};
         SEL_OVL_INDEX:  bus_value = READ_PREFIX | {8'd0, state.overlay_select};
         SEL_REV:        bus_value = REV_VALUE;
         default:        bus_value = UNMAPPED_VAL;
      endcase
   end

   always_comb begin
      read_data_in = (mode_type'(req.mode) == MODE_READ) ? bus_value : '0;
      use_ram_in   = is_lookup && (ovl_hit == '0);
      color_in     = '0;
      if (is_lookup && (ovl_hit != '0) && (ovl_idx < 8'(OVL_DEPTH))) begin
         color_in = ovl_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         load_pend_ff <= 1'b0;
      end else begin
         load_pend_ff <= accept && is_rd_strobe;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         read_data_ff <= read_data_in;
         color_ff     <= color_in;
         use_ram_ff   <= use_ram_in;
         ent_valid_ff <= entry_valid;
      end
   end

   color_type rsp_color;

   always_comb begin
      rsp_color = color_ff;
      if (use_ram_ff) begin
         rsp_color = ent_valid_ff ? ram_rd_data : '0;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = read_data_ff;
   assign rsp.red_out   = rsp_color.red;
   assign rsp.green_out = rsp_color.green;
   assign rsp.blue_out  = rsp_color.blue;

endmodule
`default_nettype wire

[tb/sv/tb_color_palette_ramdac.sv]
`default_nettype none
module tb_color_palette_ramdac;
   import cprd_pkg::*;

   localparam logic [3:0] SEL_UNMAPPED = 4'd15;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 950;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] sel;
      logic [7:0] wdata;
      logic [7:0] pixel;
      logic [7:0] ovl;
   } ramdac_request_t;

   typedef struct packed {
      logic [15:0] read_data;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } ramdac_output_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cprd_req_if req_ch ();
   cprd_rsp_if rsp_ch ();

   color_palette_ramdac i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always #10 clock = ~clock;

   color_type  video_shadow [PAL_DEPTH];
   color_type  overlay_shadow [OVL_DEPTH];
   color_type  held_color;
   logic [7:0] index_reg;
   logic [7:0] mask_reg;
   logic [7:0] ovl_ctl_reg;
   logic [7:0] ovl_sel_reg;
   logic [7:0] spare_reg;

   ramdac_request_t ramdac_requests[$];
   ramdac_output_t  expected_outputs[$];
   ramdac_request_t on_bus;
   ramdac_output_t  exp_out;

   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned results_seen = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned pattern_left = 0;
   int unsigned pattern_kind = 0;

   function automatic ramdac_output_t predict_ramdac(input ramdac_request_t r);
      ramdac_output_t res;
      color_type      c;
      logic [7:0]     o;
      res = '0;
      case (r.mode)
         MODE_READ: begin
            case (r.sel)
               SEL_BUSY:       res.read_data = 16'h0000;
               SEL_RED:        res.read_data = READ_PREFIX | {8'h00, held_color.red};
               SEL_GREEN:      res.read_data = READ_PREFIX | {8'h00, held_color.green};
               SEL_BLUE:       res.read_data = READ_PREFIX | {8'h00, held_color.blue};
               SEL_INDEX_INV:  res.read_data = READ_PREFIX | {8'h00, ~index_reg};
               SEL_INDEX:      res.read_data = READ_PREFIX | {8'h00, index_reg};
               SEL_OVL_CTL:    res.read_data = READ_PREFIX | {8'h00, ovl_ctl_reg};
               SEL_WR_STROBE:  res.read_data = READ_PREFIX;
               SEL_PLANE_MASK: res.read_data = READ_PREFIX | {8'h00, mask_reg};
               SEL_SPARE:      res.read_data = READ_PREFIX | {8'h00, spare_reg};
               SEL_OVL_INDEX:  res.read_data = READ_PREFIX | {8'h00, ovl_sel_reg};
               SEL_REV:        res.read_data = REV_VALUE;
               default:        res.read_data = UNMAPPED_VAL;
            endcase
         end
         MODE_WRITE: begin
            case (r.sel)
               SEL_RED:        held_color.red = r.wdata;
               SEL_GREEN:      held_color.green = r.wdata;
               SEL_BLUE:       held_color.blue = r.wdata;
               SEL_INDEX_INV:  index_reg = ~r.wdata;
               SEL_INDEX:      index_reg = r.wdata;
               SEL_OVL_CTL:    ovl_ctl_reg = r.wdata;
               SEL_WR_STROBE: begin
                  if (ovl_sel_reg[OVL_SEL_EN_BIT])
                     overlay_shadow[ovl_sel_reg[2:1]] = held_color;
                  else
                     video_shadow[index_reg] = held_color;
               end
               SEL_RD_STROBE:  held_color = video_shadow[index_reg];
               SEL_PLANE_MASK: mask_reg = r.wdata;
               SEL_SPARE:      spare_reg = r.wdata;
               SEL_OVL_INDEX:  ovl_sel_reg = r.wdata;
               default: ;
            endcase
         end
         MODE_LOOKUP: begin
            o = r.ovl & ovl_ctl_reg;
            if (o == 8'h00) begin
               c = video_shadow[r.pixel & mask_reg];
            end else begin
               o = o & mask_reg;
               c = (o < OVL_DEPTH) ? overlay_shadow[o[1:0]] : '0;
            end
            res.red = c.red;
            res.green = c.green;
            res.blue = c.blue;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic add_req(input logic [1:0] mode, input logic [3:0] sel,
                          input logic [7:0] wdata, input logic [7:0] pixel,
                          input logic [7:0] ovl);
      ramdac_request_t r;
      r.mode = mode;
      r.sel = sel;
      r.wdata = wdata;
      r.pixel = pixel;
      r.ovl = ovl;
      ramdac_requests.push_back(r);
   endtask

   task automatic add_write(input logic [3:0] sel, input logic [7:0] wdata);
      add_req(MODE_WRITE, sel, wdata, 8'($urandom), 8'($urandom));
   endtask

   task automatic add_read(input logic [3:0] sel);
      add_req(MODE_READ, sel, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_outputs.push_back(predict_ramdac(on_bus));
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (ramdac_requests.size() != 0) begin
               on_bus = ramdac_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.mode <= on_bus.mode;
               req_ch.reg_select <= on_bus.sel;
               req_ch.write_data <= on_bus.wdata;
               req_ch.pixel <= on_bus.pixel;
               req_ch.overlay_bits <= on_bus.ovl;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_outputs.size() == 0) begin
               $error("result with no request pending: read_data %h rgb %h %h %h",
                      rsp_ch.read_data, rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out);
               fail_count++;
            end else begin
               exp_out = expected_outputs.pop_front();
               if (rsp_ch.read_data !== exp_out.read_data) begin
                  $error("read_data: expected %h, actual %h", exp_out.read_data,
                         rsp_ch.read_data);
                  fail_count++;
               end
               if (rsp_ch.red_out !== exp_out.red) begin
                  $error("red_out: expected %h, actual %h", exp_out.red, rsp_ch.red_out);
                  fail_count++;
               end
               if (rsp_ch.green_out !== exp_out.green) begin
                  $error("green_out: expected %h, actual %h", exp_out.green, rsp_ch.green_out);
                  fail_count++;
               end
               if (rsp_ch.blue_out !== exp_out.blue) begin
                  $error("blue_out: expected %h, actual %h", exp_out.blue, rsp_ch.blue_out);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && results_seen >= 300) begin
            // hold off long enough for the block to back up into the request side
            hold_done = 1'b1;
            hold_left = 150;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_kind = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 96);
            end else begin
               pattern_left--;
            end
            case (pattern_kind)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= cycle_count[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned kind;
      int unsigned items_total;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_NONE;
      req_ch.reg_select = '0;
      req_ch.write_data = '0;
      req_ch.pixel = '0;
      req_ch.overlay_bits = '0;
      rsp_ch.ready = 1'b0;
      foreach (video_shadow[i]) video_shadow[i] = '0;
      foreach (overlay_shadow[i]) overlay_shadow[i] = '0;
      held_color = '0;
      index_reg = '0;
      mask_reg = '0;
      ovl_ctl_reg = '0;
      ovl_sel_reg = '0;
      spare_reg = '0;

      add_read(SEL_BUSY);
      add_read(SEL_REV);
      add_read(SEL_UNMAPPED);
      add_read(SEL_RD_STROBE);
      add_write(SEL_RED, 8'hFF);
      add_write(SEL_GREEN, 8'h00);
      add_write(SEL_BLUE, 8'h80);
      add_write(SEL_INDEX_INV, 8'h00);
      add_read(SEL_INDEX_INV);
      add_write(SEL_WR_STROBE, 8'h00);
      add_write(SEL_PLANE_MASK, 8'hFF);
      add_req(MODE_LOOKUP, SEL_BUSY, 8'h00, 8'hFF, 8'h00);
      add_write(SEL_OVL_INDEX, 8'h0E);
      add_write(SEL_RED, 8'h12);
      add_write(SEL_WR_STROBE, 8'hFF);
      add_write(SEL_OVL_CTL, 8'hFF);
      add_req(MODE_LOOKUP, SEL_BUSY, 8'h00, 8'h00, 8'h03);
      add_req(MODE_LOOKUP, SEL_BUSY, 8'h00, 8'hFF, 8'h80);
      add_write(SEL_INDEX, 8'h00);
      add_write(SEL_RD_STROBE, 8'h00);
      add_read(SEL_RED);
      add_write(SEL_SPARE, 8'hA5);
      add_read(SEL_SPARE);
      add_write(SEL_BUSY, 8'h55);
      add_write(SEL_UNMAPPED, 8'hAA);
      add_write(SEL_REV, 8'h00);
      add_req(MODE_NONE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

      while (ramdac_requests.size() < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            if ($urandom_range(0, 1))
               add_write(SEL_OVL_INDEX, 8'($urandom));
            add_write($urandom_range(0, 1) ? SEL_INDEX : SEL_INDEX_INV, 8'($urandom));
            add_write(SEL_RED, 8'($urandom));
            add_write(SEL_GREEN, 8'($urandom));
            add_write(SEL_BLUE, 8'($urandom));
            add_write(SEL_WR_STROBE, 8'($urandom));
         end else if (kind < 20) begin
            add_write(SEL_INDEX, 8'($urandom));
            add_write(SEL_RD_STROBE, 8'($urandom));
            add_read(SEL_RED);
            add_read(SEL_GREEN);
            add_read(SEL_BLUE);
         end else if (kind < 25) begin
            add_write($urandom_range(0, 1) ? SEL_PLANE_MASK : SEL_OVL_CTL, 8'($urandom));
         end else if (kind < 60) begin
            add_req(MODE_LOOKUP, 4'($urandom), 8'($urandom), 8'($urandom),
                    $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
         end else if (kind < 72) begin
            add_read(4'($urandom));
         end else if (kind < 96) begin
            add_write(4'($urandom), 8'($urandom));
         end else begin
            add_req(MODE_NONE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
      items_total = ramdac_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (results_seen < items_total)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
hw/rtl/cprd_pkg.sv
hw/rtl/cprd_if.sv
hw/rtl/cprd_ram.sv
hw/rtl/cprd_regs.sv
hw/rtl/color_palette_ramdac.sv
tb/sv/tb_color_palette_ramdac.sv
